### rtl/slte_pkg.sv
// ----------------------------------------------------------------------------
// slte_pkg - shared types and constants of the SML type-length encoder
// Mode codes, TL constants and the command word between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slte_pkg;

  localparam int ModeWidth  = 3;
  localparam int ValueWidth = 64;
  localparam int LenWidth   = 4;

  localparam logic [ModeWidth-1:0] MODE_END      = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_BOOL     = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_UNSIGNED = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_SIGNED   = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_OCTET    = 3'd4;
  localparam logic [ModeWidth-1:0] MODE_LIST     = 3'd5;
  localparam logic [ModeWidth-1:0] MODE_RAW      = 3'd6;

  localparam logic [7:0] TL_END           = 8'h00;
  localparam logic [7:0] TL_BOOL          = 8'h42;
  localparam logic [7:0] BOOL_TRUE        = 8'h7F;
  localparam logic [7:0] BOOL_FALSE       = 8'h00;
  localparam logic [7:0] TL_UNSIGNED_BASE = 8'h61;
  localparam logic [7:0] TL_SIGNED_BASE   = 8'h51;
  localparam logic [7:0] TL_SIGNED_LONG   = 8'h59;
  localparam logic [7:0] TL_OCTET         = 8'h00;
  localparam logic [7:0] TL_LIST          = 8'h70;
  localparam logic [7:0] TL_MORE          = 8'h80;
  localparam logic [7:0] ERROR_BYTE       = 8'h00;

  typedef enum logic [1:0] {
    OP_SINGLE,
    OP_NUMBER,
    OP_HEADER
  } op_t;

  // len is the number of bytes the command expands to (1 to 9)
  typedef struct packed {
    op_t                   op;
    logic [7:0]            first;
    logic [LenWidth-1:0]   len;
    logic [ValueWidth-1:0] data;
    logic                  err;
  } cmd_t;

endpackage

### rtl/slte_front.sv
// ----------------------------------------------------------------------------
// slte_front - item classifier
// Works out the TL byte, byte count and payload of one input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slte_front import slte_pkg::*; (
  input  logic [ModeWidth-1:0]  mode,
  input  logic [ValueWidth-1:0] value,
  output logic                  cmd_valid,
  output cmd_t                  cmd
);

  logic [LenWidth-1:0] ubytes;
  logic [LenWidth-1:0] sbytes;
  logic [LenWidth-1:0] nibs;
  logic [32:0]         sum0;
  logic [32:0]         sum1;
  logic                fits;
  logic                high_set;
  logic [5:0]          shamt;

  always_comb begin
    ubytes = LenWidth'(1);
    for (int i = 1; i < 8; i++) begin
      if (value[8*i +: 8] != 8'h00) ubytes = LenWidth'(i + 1);
    end
    nibs = LenWidth'(1);
    for (int i = 1; i < 8; i++) begin
      if (value[4*i +: 4] != 4'h0) nibs = LenWidth'(i + 1);
    end
    if (value[63:7] == {57{value[63]}}) begin
      sbytes = LenWidth'(1);
    end else if (value[63:15] == {49{value[63]}}) begin
      sbytes = LenWidth'(2);
    end else if (value[63:23] == {41{value[63]}}) begin
      sbytes = LenWidth'(3);
    end else if (value[63:31] == {33{value[63]}}) begin
      sbytes = LenWidth'(4);
    end else begin
      sbytes = LenWidth'(8);
    end
  end

  assign high_set = value[63:32] != 32'h0;
  assign sum0     = {1'b0, value[31:0]} + 33'(nibs);
  assign sum1     = sum0 + 33'd1;
  assign shamt    = {nibs, 2'b00};
  assign fits     = (sum0 >> shamt) == 33'd0;

  always_comb begin
    cmd_valid = 1'b1;
    cmd.op    = OP_SINGLE;
    cmd.first = TL_END;
    cmd.len   = LenWidth'(1);
    cmd.data  = value;
    cmd.err   = 1'b0;
    case (mode)
      MODE_END: begin
        cmd.first = TL_END;
      end
      MODE_BOOL: begin
        cmd.op    = OP_NUMBER;
        cmd.first = TL_BOOL;
        cmd.len   = LenWidth'(2);
        cmd.data  = {56'd0, (value != '0) ? BOOL_TRUE : BOOL_FALSE};
      end
      MODE_UNSIGNED: begin
        cmd.op    = OP_NUMBER;
        cmd.first = TL_UNSIGNED_BASE + 8'(ubytes);
        cmd.len   = ubytes + LenWidth'(1);
      end
      MODE_SIGNED: begin
        cmd.op    = OP_NUMBER;
        cmd.first = (sbytes == LenWidth'(8)) ? TL_SIGNED_LONG
                                             : TL_SIGNED_BASE + 8'(sbytes);
        cmd.len   = sbytes + LenWidth'(1);
      end
      MODE_OCTET: begin
        if (high_set || (!fits && nibs == LenWidth'(8))) begin
          cmd.first = ERROR_BYTE;
          cmd.err   = 1'b1;
        end else begin
          cmd.op    = OP_HEADER;
          cmd.first = TL_OCTET;
          cmd.len   = fits ? nibs : nibs + LenWidth'(1);
          cmd.data  = {31'd0, fits ? sum0 : sum1};
        end
      end
      MODE_LIST: begin
        if (high_set) begin
          cmd.first = ERROR_BYTE;
          cmd.err   = 1'b1;
        end else begin
          cmd.op    = OP_HEADER;
          cmd.first = TL_LIST;
          cmd.len   = nibs;
        end
      end
      MODE_RAW: begin
        cmd.first = value[7:0];
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/slte_queue.sv
// ----------------------------------------------------------------------------
// slte_queue - command queue
// Small register FIFO that decouples the classifier from the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slte_queue import slte_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/slte_back.sv
// ----------------------------------------------------------------------------
// slte_back - byte serialiser
// Expands queued commands into output words through a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slte_back import slte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_err
);

  cmd_t                cur;
  logic                busy;
  logic                at_first;
  logic [LenWidth-1:0] pos;
  logic                advance;
  logic                finishing;
  logic [7:0]          byte_next;
  logic [5:0]          bsel;
  logic [5:0]          nsel;

  assign advance   = !out_valid || out_ready;
  assign finishing = busy && advance && pos == '0;
  assign pop       = head_valid && (!busy || finishing);
  assign bsel      = {pos[2:0], 3'b000};
  assign nsel      = {1'b0, pos[2:0], 2'b00};

  always_comb begin
    case (cur.op)
      OP_NUMBER: begin
        byte_next = at_first ? cur.first : cur.data[bsel +: 8];
      end
      OP_HEADER: begin
        byte_next = {4'h0, cur.data[nsel +: 4]}
                  | (at_first ? cur.first : 8'h00)
                  | ((pos != '0) ? TL_MORE : 8'h00);
      end
      default: begin
        byte_next = cur.first;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head_cmd;
      pos      <= head_cmd.len - LenWidth'(1);
      at_first <= 1'b1;
    end else if (busy && advance) begin
      pos      <= pos - LenWidth'(1);
      at_first <= 1'b0;
    end
    if (busy && advance) begin
      out_byte <= byte_next;
      out_last <= pos == '0;
      out_err  <= cur.err;
    end
  end

endmodule

### rtl/sml_type_length_value_encoder.sv
// ----------------------------------------------------------------------------
// sml_type_length_value_encoder - SML type-length-value encoder
// Turns mode/value words into SML TL-encoded bytes, last byte marked.
//
//  channel | dir | tdata                          | side
//  s_axis  | in  | mode[2:0], value[66:3], pad    | -
//  m_axis  | out | out_byte[7:0]                  | tlast=last, tuser=error
//
// One output word per cycle while the output is not stalled; an input word
// expands to 1 to 9 bytes. Classification and queue write happen in the
// cycle of acceptance; the serialiser's command and output registers follow.
// Reset empties the queue and clears output valid. A stalled output backs up
// into the queue, and input is taken while the queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sml_type_length_value_encoder import slte_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // mode[2:0], value[66:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // error
);

  logic cls_valid;
  cmd_t cls_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  slte_front u_front (
    .mode      (s_axis_tdata[2:0]),
    .value     (s_axis_tdata[66:3]),
    .cmd_valid (cls_valid),
    .cmd       (cls_cmd)
  );

  assign s_axis_tready = !q_full;

  slte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid && cls_valid),
    .push_cmd   (cls_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  slte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_err    (m_axis_tuser)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the SML type-length-value encoder
// Streams mode/value words into the encoder under bursty input and a stalling
// output, predicts every encoded byte with its last and error marks, and
// compares each byte taken from the output against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
  import slte_pkg::*;

  localparam logic [ModeWidth-1:0] MODE_UNUSED = 3'd7;
  localparam int NUM_ITEMS    = 276;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [ModeWidth-1:0]  mode;
    logic [ValueWidth-1:0] value;
  } word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } tl_byte_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  word_t    pending_words[$];
  tl_byte_t expected_bytes[$];
  word_t    next_word;
  tl_byte_t want;

  int fails          = 0;
  int bytes_checked  = 0;
  int err_bytes      = 0;
  int words_accepted = 0;
  int mode_count[8];
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int bytes_seen_rx  = 0;
  int phase_left     = 0;
  int stall_kind     = 0;
  int n_random       = 0;

  sml_type_length_value_encoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // ---- encoding predictor ----

  function automatic void push_byte(logic [7:0] b, logic l, logic e);
    tl_byte_t t;
    t.data = b;
    t.last = l;
    t.err  = e;
    expected_bytes.push_back(t);
  endfunction

  function automatic void push_number(logic [7:0] tl, logic [63:0] v, int n);
    push_byte(tl, 1'b0, 1'b0);
    for (int i = n; i > 0; i--) begin
      push_byte(v[8*(i-1) +: 8], i == 1, 1'b0);
    end
  endfunction

  // length field: octet lengths include the TL bytes themselves
  function automatic void push_header(logic [63:0] v, logic [7:0] kind, bit self_len);
    logic [63:0] lim;
    logic [63:0] t;
    logic [63:0] total;
    logic [7:0]  b;
    int          k;
    bit          found;
    found = 1'b0;
    total = '0;
    k     = 0;
    for (int j = 1; j <= 8 && !found; j++) begin
      lim = (64'd1 << (4 * j)) - 64'd1;
      t   = self_len ? v + 64'(j) : v;
      if (!(self_len && v > lim) && t <= lim) begin
        found = 1'b1;
        total = t;
        k     = j;
      end
    end
    if (!found) begin
      push_byte(ERROR_BYTE, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < k; i++) begin
        b = {4'h0, total[4*(k-1-i) +: 4]};
        if (i == 0) b = b | kind;
        if (i + 1 < k) b = b | TL_MORE;
        push_byte(b, i + 1 == k, 1'b0);
      end
    end
  endfunction

  function automatic void encode_word(logic [ModeWidth-1:0] md, logic [63:0] val);
    int          n;
    bit          done;
    logic [63:0] top;
    logic [63:0] ones;
    case (md)
      MODE_END: begin
        push_byte(TL_END, 1'b1, 1'b0);
      end
      MODE_BOOL: begin
        push_byte(TL_BOOL, 1'b0, 1'b0);
        push_byte((val != '0) ? BOOL_TRUE : BOOL_FALSE, 1'b1, 1'b0);
      end
      MODE_UNSIGNED: begin
        n = 1;
        while (n < 8 && (val >> (8 * n)) != '0) n++;
        push_number(TL_UNSIGNED_BASE + 8'(n), val, n);
      end
      MODE_SIGNED: begin
        done = 1'b0;
        for (int w = 1; w <= 4 && !done; w++) begin
          top  = val >> (8 * w - 1);
          ones = {64{1'b1}} >> (8 * w - 1);
          if (top == '0 || top == ones) begin
            push_number(TL_SIGNED_BASE + 8'(w), val, w);
            done = 1'b1;
          end
        end
        if (!done) push_number(TL_SIGNED_LONG, val, 8);
      end
      MODE_OCTET: begin
        push_header(val, TL_OCTET, 1'b1);
      end
      MODE_LIST: begin
        push_header(val, TL_LIST, 1'b0);
      end
      MODE_RAW: begin
        push_byte(val[7:0], 1'b1, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  // ---- stimulus ----

  function automatic void add_word(logic [ModeWidth-1:0] md, logic [63:0] val);
    word_t w;
    w.mode  = md;
    w.value = val;
    pending_words.push_back(w);
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] r;
    int          kind;
    int          k;
    r    = {$urandom, $urandom};
    kind = $urandom_range(0, 5);
    case (kind)
      1: r = r >> $urandom_range(0, 63);
      2: r = ~(r >> $urandom_range(1, 63));
      3: r = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
      4: r = 64'($urandom_range(0, 255));
      5: begin
        k = $urandom_range(1, 9);
        r = (k == 9) ? r : (64'd1 << (4 * k)) - 64'($urandom_range(0, 9));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---- driver: bursts with random gaps ----

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_word(s_axis_tdata[2:0], s_axis_tdata[66:3]);
        words_accepted++;
        mode_count[int'(s_axis_tdata[2:0])]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, next_word.value, next_word.mode};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: changing stall patterns, one long hold-off ----

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) bytes_seen_rx++;
      if (!hold_done && bytes_seen_rx >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_kind = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        case (stall_kind)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (phase_left % 3 != 0);
        endcase
      end
    end
  end

  // ---- monitor ----

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %h last %b error %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fails++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.data) begin
          $display("%0t: byte mismatch: expected %h, got %h", $time, want.data, m_axis_tdata);
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, m_axis_tlast);
          fails++;
        end
        if (m_axis_tuser !== want.err) begin
          $display("%0t: error mismatch: expected %b, got %b", $time, want.err, m_axis_tuser);
          fails++;
        end
      end
      bytes_checked++;
      if (m_axis_tuser) err_bytes++;
    end
  end

  // ---- sequence ----

  initial begin
    for (int i = 0; i < 8; i++) mode_count[i] = 0;

    add_word(MODE_END,      64'h0);
    add_word(MODE_BOOL,     64'h0);
    add_word(MODE_BOOL,     64'h8000_0000_0000_0000);
    add_word(MODE_UNSIGNED, 64'h0);
    add_word(MODE_UNSIGNED, 64'hFF);
    add_word(MODE_UNSIGNED, 64'h100);
    add_word(MODE_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
    add_word(MODE_SIGNED,   64'h7F);
    add_word(MODE_SIGNED,   64'h80);
    add_word(MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FF80);
    add_word(MODE_SIGNED,   64'h7FFF_FFFF);
    add_word(MODE_SIGNED,   64'h8000_0000);
    add_word(MODE_SIGNED,   64'h8000_0000_0000_0000);
    add_word(MODE_OCTET,    64'd14);
    add_word(MODE_OCTET,    64'd15);
    add_word(MODE_OCTET,    64'hFFFF_FFF7);
    add_word(MODE_OCTET,    64'hFFFF_FFF8);
    add_word(MODE_OCTET,    64'hFFFF_FFFF_FFFF_FFFF);
    add_word(MODE_LIST,     64'd15);
    add_word(MODE_LIST,     64'd16);
    add_word(MODE_LIST,     64'hFFFF_FFFF);
    add_word(MODE_LIST,     64'h1_0000_0000);
    add_word(MODE_RAW,      64'hFFFF_FFFF_FFFF_FFFF);
    add_word(MODE_UNUSED,   64'hFFFF_FFFF_FFFF_FFFF);

    while (n_random < NUM_ITEMS) begin
      if ($urandom_range(0, 99) < 3) begin
        add_word(MODE_UNUSED, random_value());
      end else begin
        add_word(3'($urandom_range(0, 6)), random_value());
        n_random++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words (%0d of the unused mode) and %0d bytes, %0d flagged.",
             words_accepted, mode_count[7], bytes_checked, err_bytes);
    $display("Words per mode end/bool/uns/sgn/octet/list/raw: %0d %0d %0d %0d %0d %0d %0d",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5], mode_count[6]);
    if (fails == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
